/* hw/rtl/assert_macros.svh */
// Assertion macros used by the debounce core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* hw/rtl/bdl_pkg.sv */
// Shared types and constants of the button debounce and long-press block.
`timescale 1ns / 1ps

package bdl_pkg;

   localparam int TIMER_WIDTH_DEFAULT = 16;
   localparam int CFG_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH     = 8;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_PRESS = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_REPEAT     = 8'd2;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd30;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd600;
   localparam logic [CFG_WIDTH-1:0] REPEAT_RESET     = 16'd200;

   typedef enum logic [1:0] {
      EV_NONE       = 2'd0,
      EV_SHORT      = 2'd1,
      EV_LONG_START = 2'd2,
      EV_REPEAT     = 2'd3
   } event_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
      logic [CFG_WIDTH-1:0] repeat_ticks;
   } cfg_type;

endpackage

/* hw/rtl/bdl_core.sv */
// Debounce filter and press classifier state, one sample per accepted item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdl_core
   import bdl_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  logic      level,
   input  cfg_type   cfg,
   output event_type event_code
);

   localparam int CMP_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_PRESSED = 2'd1,
      ST_LONG    = 2'd2
   } state_type;

   logic                   candidate_ff, candidate_in;
   logic                   stable_ff, stable_in;
   logic [TIMER_WIDTH-1:0] settle_ff, settle_in;
   logic [TIMER_WIDTH-1:0] hold_ff, hold_in;
   state_type              state_ff, state_in;

   logic                   commit;
   logic                   press_edge;
   logic                   release_edge;
   logic [TIMER_WIDTH-1:0] hold_inc;

   // Restart the settle timer on a changed sample, otherwise count up and saturate
   always_comb begin
      candidate_in = level;
      if (level != candidate_ff) begin
         settle_in = '0;
      end else if (settle_ff == '1) begin
         settle_in = settle_ff;
      end else begin
         settle_in = settle_ff + 1'b1;
      end
   end

   // Commit the candidate once it has held long enough
   assign commit = (CMP_WIDTH'(settle_in) >= CMP_WIDTH'(cfg.debounce_ticks)) &&
                   (candidate_in != stable_ff);
   assign press_edge   = commit && stable_ff;
   assign release_edge = commit && !stable_ff;
   assign stable_in    = commit ? candidate_in : stable_ff;

   assign hold_inc = (hold_ff == '1) ? hold_ff : hold_ff + 1'b1;

   // Classify the press from edges and the hold timer
   always_comb begin
      state_in   = state_ff;
      hold_in    = hold_ff;
      event_code = EV_NONE;
      unique case (state_ff)
         ST_PRESSED: begin
            hold_in = hold_inc;
            if (release_edge) begin
               state_in   = ST_IDLE;
               event_code = EV_SHORT;
            end else if (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.long_press_ticks)) begin
               state_in   = ST_LONG;
               hold_in    = '0;
               event_code = EV_LONG_START;
            end
         end
         ST_LONG: begin
            hold_in = hold_inc;
            if (release_edge) begin
               state_in = ST_IDLE;
            end else if (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.repeat_ticks)) begin
               hold_in    = '0;
               event_code = EV_REPEAT;
            end
         end
         default: begin
            // idle, and the unused code, which behaves as idle
            if (press_edge) begin
               state_in = ST_PRESSED;
               hold_in  = '0;
            end
         end
      endcase
   end

   // Hold state between items, advance on each accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= 1'b1;
         stable_ff    <= 1'b1;
         settle_ff    <= '0;
         hold_ff      <= '0;
         state_ff     <= ST_IDLE;
      end else if (step) begin
         candidate_ff <= candidate_in;
         stable_ff    <= stable_in;
         settle_ff    <= settle_in;
         hold_ff      <= hold_in;
         state_ff     <= state_in;
      end
   end

   `ASSERT_IMPLIES(a_short_from_pressed, clock, reset, step && event_code == EV_SHORT, state_ff == ST_PRESSED && release_edge)
   `ASSERT_NEXT(a_long_start_clears_hold, clock, reset, step && event_code == EV_LONG_START, state_ff == ST_LONG && hold_ff == '0)
   `ASSERT_NEXT(a_stable_holds_when_idle, clock, reset, !step, $stable(stable_ff) && $stable(state_ff))

endmodule

/* hw/rtl/button_debounce_long_press.sv */
// An accepted sample's event is computed combinationally and registered in the result register on accept.
// Throughput: one sample per cycle while the result is taken; the result register frees as it is taken.
// The debounce and press state update once per accepted sample.
// Reset (synchronous) restores the register defaults, released levels, idle state
// and zero timers, and empties the result register.
`timescale 1ns / 1ps

module button_debounce_long_press
   import bdl_pkg::*;
#(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_button_level,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_press_event,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   cfg_type   cfg_ff;
   event_type event_code;
   event_type event_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Write configuration registers; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_DEBOUNCE:   cfg_ff.debounce_ticks   <= csr_data;
            REG_LONG_PRESS: cfg_ff.long_press_ticks <= csr_data;
            REG_REPEAT:     cfg_ff.repeat_ticks     <= csr_data;
            default: ;
         endcase
      end
   end

   bdl_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .level      (req_button_level),
      .cfg        (cfg_ff),
      .event_code (event_code)
   );

   // Load the result register on accept, hold it until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff <= event_code;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = event_ff;

endmodule
